@@ design/stst_pkg.sv @@
// shared constants and types for the timer slot table
package stst_pkg;

  // default number of timer slots
  localparam int SLOTS_DEF = 8;

  // most fire results one tick may produce
  localparam int MAX_RESULTS = 8;

  // input item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SCHED  = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // result kinds
  localparam logic RES_SCHED = 1'b0;
  localparam logic RES_FIRE  = 1'b1;

  // write strobes into the slot store
  typedef struct packed {
    logic trig_we;
    logic per_we;
  } stst_wr_t;

endpackage

@@ design/stst_slot_store.sv @@
// trigger time and period storage, one write and one registered read per cycle
module stst_slot_store import stst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic [IW-1:0] addr,
  input  stst_wr_t      wr,
  input  logic [31:0]   trig_wdata,
  input  logic [31:0]   per_wdata,
  output logic [31:0]   trig_rdata,
  output logic [31:0]   per_rdata
);

  logic [31:0] trig_mem [SLOTS];
  logic [31:0] per_mem  [SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.trig_we) begin
      trig_mem[addr] <= trig_wdata;
    end
    if (wr.per_we) begin
      per_mem[addr] <= per_wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    trig_rdata <= trig_mem[addr];
    per_rdata  <= per_mem[addr];
  end

endmodule

@@ design/software_timer_slot_table.sv @@
// timer slot table: schedule, cancel and tick scan over a shared 32-bit adder
// cancel and unused kind are handled in the idle state; schedule searches the slots for a free one
// tick: free slots are skipped; armed slots are read and tested, fired one-shots are freed and
// fired periodic slots re-armed; a full output register stalls the emit; next item after the scan
// reset clears the active bits and the sequencer; trigger and period storage is not cleared
module software_timer_slot_table import stst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_delay_ms,
  input  logic        in_repeat_flag,
  input  logic [7:0]  in_cancel_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [3:0]  out_slot_id,
  output logic        out_last
);

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCHED, S_RD, S_EV, S_UPD, S_POST, S_EMIT, S_ADV, S_FIN
  } state_t;

  state_t           state_r;
  state_t           emit_ret_r;
  logic [SLOTS-1:0] active_r;
  logic [IW-1:0]    idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      now_r;
  logic [31:0]      delay_r;
  logic             rep_r;
  logic             pend_valid_r;
  logic [3:0]       pend_id_r;
  logic [3:0]       emit_id_r;
  logic             emit_kind_r;
  logic             emit_last_r;
  logic             out_valid_r;
  logic             out_kind_r;
  logic [3:0]       out_id_r;
  logic             out_last_r;

  logic [31:0]      rd_trig;
  logic [31:0]      rd_per;
  logic [31:0]      add_b;
  logic             add_cin;
  logic [31:0]      add_sum;
  logic             due;
  logic [3:0]       cur_id;
  logic             scan_done;
  logic             in_acc;
  logic             cancel_hit;
  logic [IW-1:0]    cancel_idx;
  stst_wr_t         wr;

  assign in_ready        = (state_r == S_IDLE);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_slot_id     = out_id_r;
  assign out_last        = out_last_r;

  // cancel decode
  assign cancel_hit = (in_cancel_id != 8'd0) && (in_cancel_id <= 8'(SLOTS));
  assign cancel_idx = IW'(in_cancel_id - 8'd1);

  // shared adder: now + delay, now - trigger, now + period
  always_comb begin
    add_b   = delay_r;
    add_cin = 1'b0;
    case (state_r)
      S_EV: begin
        add_b   = ~rd_trig;
        add_cin = 1'b1;
      end
      S_UPD:   add_b = rd_per;
      default: add_b = delay_r;
    endcase
  end
  assign add_sum = now_r + add_b + {31'd0, add_cin};
  assign due     = (add_sum[31:1] == 31'd0);

  assign cur_id    = 4'({1'b0, idx_r} + (IW + 1)'(1));
  assign scan_done = (cnt_r == CNT_W'(MAX_RESULTS)) || (idx_r == LAST_IDX);

  // store write strobes
  always_comb begin
    wr.trig_we = ((state_r == S_SCHED) && !active_r[idx_r]) || (state_r == S_UPD);
    wr.per_we  = (state_r == S_SCHED) && !active_r[idx_r];
  end

  stst_slot_store #(.SLOTS(SLOTS)) u_store (
    .clk        (clk),
    .addr       (idx_r),
    .wr         (wr),
    .trig_wdata (add_sum),
    .per_wdata  (rep_r ? delay_r : 32'd0),
    .trig_rdata (rd_trig),
    .per_rdata  (rd_per)
  );

  // sequencer, slot flags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      emit_ret_r   <= S_IDLE;
      active_r     <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // the emit state reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r        <= in_now_ms;
            delay_r      <= in_delay_ms;
            rep_r        <= in_repeat_flag;
            idx_r        <= '0;
            cnt_r        <= '0;
            pend_valid_r <= 1'b0;
            case (in_kind)
              KIND_SCHED: state_r <= S_SCHED;
              KIND_TICK:  state_r <= S_RD;
              KIND_CANCEL: begin
                if (cancel_hit) begin
                  active_r[cancel_idx] <= 1'b0;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        // first free slot search
        S_SCHED: begin
          emit_kind_r <= RES_SCHED;
          emit_last_r <= 1'b1;
          emit_ret_r  <= S_IDLE;
          if (!active_r[idx_r]) begin
            active_r[idx_r] <= 1'b1;
            emit_id_r       <= cur_id;
            state_r         <= S_EMIT;
          end else if (idx_r == LAST_IDX) begin
            emit_id_r <= 4'd0;
            state_r   <= S_EMIT;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        // tick scan: skip free slots, else wait for stored values
        S_RD: begin
          if (active_r[idx_r]) begin
            state_r <= S_EV;
          end else if (scan_done) begin
            state_r <= S_FIN;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_EV: begin
          if (due) begin
            cnt_r <= cnt_r + CNT_W'(1);
            if (rd_per != 32'd0) begin
              state_r <= S_UPD;
            end else begin
              active_r[idx_r] <= 1'b0;
              state_r         <= S_POST;
            end
          end else if (scan_done) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + IW'(1);
            state_r <= S_RD;
          end
        end
        S_UPD: state_r <= S_POST;
        // hold the newest fire back so the final one can carry last
        S_POST: begin
          pend_valid_r <= 1'b1;
          pend_id_r    <= cur_id;
          if (pend_valid_r) begin
            emit_id_r   <= pend_id_r;
            emit_kind_r <= RES_FIRE;
            emit_last_r <= 1'b0;
            emit_ret_r  <= S_ADV;
            state_r     <= S_EMIT;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          if (scan_done) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + IW'(1);
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          if (pend_valid_r) begin
            pend_valid_r <= 1'b0;
            emit_id_r    <= pend_id_r;
            emit_kind_r  <= RES_FIRE;
            emit_last_r  <= 1'b1;
            emit_ret_r   <= S_IDLE;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        // load the output register once it is free
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= emit_kind_r;
            out_id_r    <= emit_id_r;
            out_last_r  <= emit_last_r;
            state_r     <= emit_ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_fire_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RES_FIRE) |-> (out_slot_id != 4'd0))
    else $error("fire word with slot id zero");

  a_cancel_frees: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == KIND_CANCEL) && cancel_hit |=> !active_r[$past(cancel_idx)])
    else $error("cancelled slot still active");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("fire count above limit");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_valid_r)
    else $error("ready with a held fire word");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the timer slot table: directed rows, then random words
module testbench;
  import stst_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_WORDS = 440;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_LIMIT = 10;
  localparam int IDLE_PCT = 29;

  // one result word as the block reports it
  typedef struct packed {
    logic       rkind;
    logic [3:0] slot;
    logic       last;
  } report_t;

  // one input word, plus an optional typed-in schedule answer
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [31:0] delay;
    logic        rep;
    logic [7:0]  cid;
    logic        typed;
    logic        answered;
    logic [3:0]  slot;
  } step_t;

  // directed rows; typed rows carry the answer, the rest go through the timer model
  localparam step_t PLAN [22] = '{
    // tick on an empty table
    '{KIND_TICK,   32'd0,         32'd0,         1'b0, 8'd0,   1'b1, 1'b0, 4'd0},
    // fill all slots so that every one comes due at 4 or 5
    '{KIND_SCHED,  32'd0,         32'd5,         1'b0, 8'd0,   1'b1, 1'b1, 4'd1},
    '{KIND_SCHED,  32'hFFFF_FFFF, 32'd6,         1'b1, 8'd0,   1'b1, 1'b1, 4'd2},
    '{KIND_SCHED,  32'd4,         32'd0,         1'b1, 8'd0,   1'b1, 1'b1, 4'd3},
    '{KIND_SCHED,  32'd0,         32'd4,         1'b1, 8'd0,   1'b1, 1'b1, 4'd4},
    '{KIND_SCHED,  32'd0,         32'd5,         1'b1, 8'd0,   1'b1, 1'b1, 4'd5},
    '{KIND_SCHED,  32'd1,         32'd4,         1'b0, 8'd0,   1'b1, 1'b1, 4'd6},
    '{KIND_SCHED,  32'd2,         32'd3,         1'b1, 8'd0,   1'b1, 1'b1, 4'd7},
    '{KIND_SCHED,  32'd0,         32'd5,         1'b0, 8'd0,   1'b1, 1'b1, 4'd8},
    // table full
    '{KIND_SCHED,  32'd0,         32'd1,         1'b0, 8'd0,   1'b1, 1'b1, 4'd0},
    // one before the earliest trigger
    '{KIND_TICK,   32'd3,         32'd0,         1'b0, 8'd0,   1'b1, 1'b0, 4'd0},
    // all eight fire at once, then some of the re-armed ones
    '{KIND_TICK,   32'd5,         32'd0,         1'b0, 8'd0,   1'b0, 1'b0, 4'd0},
    '{KIND_TICK,   32'd10,        32'd0,         1'b0, 8'd0,   1'b0, 1'b0, 4'd0},
    // largest time and delay, firing across the wrap
    '{KIND_SCHED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0,   1'b1, 1'b1, 4'd1},
    '{KIND_TICK,   32'hFFFF_FFFF, 32'd0,         1'b0, 8'd0,   1'b0, 1'b0, 4'd0},
    // ignored cancel ids and the spare kind
    '{KIND_CANCEL, 32'd0,         32'd0,         1'b0, 8'd0,   1'b1, 1'b0, 4'd0},
    '{KIND_CANCEL, 32'd0,         32'd0,         1'b0, 8'd9,   1'b1, 1'b0, 4'd0},
    '{KIND_CANCEL, 32'd0,         32'd0,         1'b0, 8'd255, 1'b1, 1'b0, 4'd0},
    '{KIND_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd255, 1'b1, 1'b0, 4'd0},
    // cancel an armed slot, then the same slot while free
    '{KIND_CANCEL, 32'd0,         32'd0,         1'b0, 8'd1,   1'b1, 1'b0, 4'd0},
    '{KIND_CANCEL, 32'd0,         32'd0,         1'b0, 8'd1,   1'b1, 1'b0, 4'd0},
    '{KIND_SCHED,  32'd20,        32'd2,         1'b0, 8'd0,   1'b1, 1'b1, 4'd1}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_TICK;
  logic [31:0] in_now_ms = '0;
  logic [31:0] in_delay_ms = '0;
  logic        in_repeat_flag = 1'b0;
  logic [7:0]  in_cancel_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [3:0]  out_slot_id;
  logic        out_last;

  // typed-in answer travelling with the word on the input side
  logic        row_typed = 1'b0;
  logic        row_answered = 1'b0;
  logic [3:0]  row_slot = '0;

  logic        burst_mode = 1'b0;
  int          quiet_cycles = 0;
  int          fail_count = 0;

  // timer model state
  logic        armed [NSLOT];
  logic [31:0] due_at [NSLOT];
  logic [31:0] reload [NSLOT];
  report_t     fresh_reports [$];
  report_t     pending_reports [$];

  software_timer_slot_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_now_ms      (in_now_ms),
    .in_delay_ms    (in_delay_ms),
    .in_repeat_flag (in_repeat_flag),
    .in_cancel_id   (in_cancel_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_kind(out_result_kind),
    .out_slot_id    (out_slot_id),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one word to the timer model, leaving its results in fresh_reports
  function automatic void step_timers(logic [1:0] kind, logic [31:0] now,
                                      logic [31:0] delay, logic rep, logic [7:0] cid);
    int fired [$];
    int free_slot;
    free_slot = -1;
    fresh_reports.delete();
    case (kind)
      KIND_SCHED: begin
        for (int i = 0; i < NSLOT; i++)
          if (free_slot < 0 && !armed[i]) free_slot = i;
        if (free_slot < 0) begin
          fresh_reports.push_back('{RES_SCHED, 4'd0, 1'b1});
        end else begin
          armed[free_slot] = 1'b1;
          due_at[free_slot] = now + delay;
          reload[free_slot] = rep ? delay : 32'd0;
          fresh_reports.push_back('{RES_SCHED, 4'(free_slot + 1), 1'b1});
        end
      end
      KIND_CANCEL: begin
        if (cid != 8'd0 && cid <= NSLOT) armed[cid - 8'd1] = 1'b0;
      end
      KIND_TICK: begin
        // lowest slots first, capped at the result room
        for (int i = 0; i < NSLOT; i++) begin
          if (fired.size() < MAX_RESULTS && armed[i] && (now - due_at[i]) <= 32'd1) begin
            if (reload[i] != 32'd0) due_at[i] = now + reload[i];
            else armed[i] = 1'b0;
            fired.push_back(i);
          end
        end
        foreach (fired[j])
          fresh_reports.push_back('{RES_FIRE, 4'(fired[j] + 1), 1'(j == fired.size() - 1)});
      end
      default: ;
    endcase
  endfunction

  function automatic void report_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $realtime, what);
  endfunction

  // watch both channels: predict on input words, check output words
  always @(posedge clk) begin : scoreboard
    report_t got;
    report_t want;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) armed[i] = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_timers(in_kind, in_now_ms, in_delay_ms, in_repeat_flag, in_cancel_id);
        if (row_typed) begin
          if (row_answered) pending_reports.push_back('{RES_SCHED, row_slot, 1'b1});
        end else begin
          foreach (fresh_reports[k]) pending_reports.push_back(fresh_reports[k]);
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_result_kind, out_slot_id, out_last};
        if (pending_reports.size() == 0) begin
          report_failure($sformatf("word with nothing pending: kind %0d slot %0d last %0d",
                                   got.rkind, got.slot, got.last));
        end else begin
          want = pending_reports.pop_front();
          if (got.rkind !== want.rkind || got.slot !== want.slot || got.last !== want.last)
            report_failure($sformatf("exp kind %0d slot %0d last %0d, got %0d %0d %0d",
                                     want.rkind, want.slot, want.last,
                                     got.rkind, got.slot, got.last));
        end
      end
      quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                      0 : quiet_cycles + 1;
    end
  end

  // receiver stalls at random outside the burst stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // present one word, with random gaps ahead of it, and wait for it to be taken
  task automatic send_word(step_t s);
    while (!burst_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= s.kind;
    in_now_ms <= s.now;
    in_delay_ms <= s.delay;
    in_repeat_flag <= s.rep;
    in_cancel_id <= s.cid;
    row_typed <= s.typed;
    row_answered <= s.answered;
    row_slot <= s.slot;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  initial begin : stimulus
    step_t s;
    logic [31:0] wall_ms;
    int counted;
    int pick;
    bit paused;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < $size(PLAN); r++) send_word(PLAN[r]);

    // random words around a running millisecond clock
    wall_ms = $urandom;
    counted = 0;
    paused = 1'b0;
    while (counted < RANDOM_WORDS) begin
      burst_mode <= (counted >= 120 && counted < 200);
      if (counted >= 300 && !paused) begin
        // let the table drain completely once
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
      end
      s = '0;
      s.now = $urandom;
      s.delay = $urandom;
      s.rep = 1'($urandom);
      s.cid = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        s.kind = KIND_TICK;
        // mostly the next millisecond, sometimes a jump, sometimes a stray time
        if ($urandom_range(0, 24) != 0) begin
          wall_ms = wall_ms + (($urandom_range(0, 19) == 0) ? 32'($urandom_range(2, 40)) : 32'd1);
          s.now = wall_ms;
        end
      end else if (pick < 78) begin
        s.kind = KIND_SCHED;
        s.now = wall_ms;
        if ($urandom_range(0, 7) != 0) s.delay = $urandom_range(0, 12);
      end else if (pick < 95) begin
        s.kind = KIND_CANCEL;
        if ($urandom_range(0, 5) != 0) s.cid = 8'($urandom_range(0, NSLOT + 1));
      end else begin
        s.kind = KIND_SPARE;
      end
      send_word(s);
      if (s.kind != KIND_SPARE) counted++;
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // give up when neither channel moves for too long
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
